// File: design/srld_pkg.sv
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types, widths and codes for the sprite run-length pixel decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int CFG_W    = 13;
  localparam int CMP_W    = CFG_W + 1;
  localparam int COL_W    = 14;
  localparam int ROW_W    = 13;
  localparam int LEN_W    = 12;
  localparam int CODE_W   = 8;
  localparam int INDEX_W  = 24;
  localparam int COLOUR_W = 32;
  localparam int STATUS_W = 2;
  localparam int PROD_W   = ROW_W + DIM_W;
  localparam int SUM_W    = 32;

  localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
  localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(240);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_PIXEL  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  typedef struct packed {
    logic              mode;
    logic              run_done;
    logic              start_of_row;
    logic [LEN_W-1:0]  skip_length;
    logic [LEN_W-1:0]  run_length;
    logic [CODE_W-1:0] pixel_code;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  pixel_index;
    logic [COLOUR_W-1:0] colour_word;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic logic [COLOUR_W-1:0] widen_colour(input logic [CODE_W-1:0] code);
    logic [1:0] b;
    logic [2:0] g;
    logic [2:0] r;
    b = code[7:6];
    g = code[5:3];
    r = code[2:0];
    return {ALPHA_OPAQUE, {b, b, b, b}, {g, g, g[2:1]}, {r, r, r[2:1]}};
  endfunction

endpackage

// File: design/srld_cfg_regs.sv
// ----------------------------------------------------------------------------
// srld_cfg_regs
// Image size registers, clamped to the largest supported dimension.
// ----------------------------------------------------------------------------
module srld_cfg_regs import srld_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output dims_t            dims
);

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [CFG_W-1:0] width_nxt;
  logic [CFG_W-1:0] height_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (wr_index)
        REG_IMAGE_WIDTH:  width_nxt  = wr_data;
        REG_IMAGE_HEIGHT: height_nxt = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign dims.width  = (CMP_W'(width_r) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : DIM_W'(width_r);
  assign dims.height = (CMP_W'(height_r) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                             : DIM_W'(height_r);

endmodule

// File: design/srld_core.sv
// ----------------------------------------------------------------------------
// srld_core
// Cursor state (column, row, pixels left) and the per-word decode.
// ----------------------------------------------------------------------------
module srld_core import srld_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  input  dims_t   dims,
  output logic    has_result,
  output result_t result
);

  logic [COL_W-1:0]  column_r;
  logic [COL_W-1:0]  column_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [LEN_W-1:0]  left_r;
  logic [LEN_W-1:0]  left_nxt;
  logic [COL_W-1:0]  col_base;
  logic [COL_W:0]    col_sum;
  logic              in_image;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  index_sum;

  assign in_image  = (15'(column_r) < 15'(dims.width)) && (15'(row_r) < 15'(dims.height));
  assign prod      = PROD_W'(row_r) * PROD_W'(dims.width);
  assign index_sum = SUM_W'(prod) + SUM_W'(column_r);
  assign col_base  = item.start_of_row ? '0 : column_r;
  assign col_sum   = (COL_W + 1)'(col_base) + (COL_W + 1)'(item.skip_length);

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    left_nxt   = left_r;
    has_result = 1'b0;
    result     = '0;
    case (item.mode)
      MODE_HEADER: begin
        if (item.run_done) begin
          column_nxt    = '0;
          row_nxt       = '0;
          left_nxt      = '0;
          has_result    = 1'b1;
          result.status = ST_DONE;
        end else begin
          if (item.start_of_row && (row_r != ROW_MAX)) begin
            row_nxt = row_r + 1'b1;
          end
          column_nxt = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
          left_nxt   = item.run_length;
        end
      end
      MODE_PIXEL: begin
        has_result = 1'b1;
        if (left_r == '0) begin
          result.status = ST_BEYOND;
        end else begin
          left_nxt = left_r - 1'b1;
          if (column_r != COL_MAX) begin
            column_nxt = column_r + 1'b1;
          end
          if (in_image) begin
            result.status      = ST_WRITTEN;
            result.pixel_index = index_sum[INDEX_W-1:0];
            result.colour_word = widen_colour(item.pixel_code);
          end else begin
            result.status = ST_OUTSIDE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      left_r   <= '0;
    end else if (advance) begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

// File: design/sprite_run_length_pixel_decoder.sv
// ----------------------------------------------------------------------------
// sprite_run_length_pixel_decoder
// Turns run-length sprite words (run headers and pixel bytes) into pixel writes.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle unless the output side stalls. A word is
// held in an input register and decoded combinationally against the cursor
// state; its result, if it has one, is written into the output register that
// drives out_valid. The output register stalls the input side only when it
// holds an untaken result and the next word also produces one; run headers
// without the done flag produce no result and pass even then. Image size writes
// take effect immediately and should only be made while the decoder is idle.
module sprite_run_length_pixel_decoder import srld_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic                in_run_done,
  input  logic                in_start_of_row,
  input  logic [LEN_W-1:0]    in_skip_length,
  input  logic [LEN_W-1:0]    in_run_length,
  input  logic [CODE_W-1:0]   in_pixel_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [INDEX_W-1:0]  out_pixel_index,
  output logic [COLOUR_W-1:0] out_colour_word,
  output logic [STATUS_W-1:0] out_status
);

  dims_t   dims;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  logic    s1_proc;
  logic    in_fire;
  logic    out_free;
  logic    has_result;
  result_t result;
  result_t out_r;
  logic    out_valid_r;
  logic    out_valid_nxt;

  assign cfg_ready = 1'b1;

  srld_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .dims     (dims)
  );

  srld_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_proc),
    .item       (s1_item_r),
    .dims       (dims),
    .has_result (has_result),
    .result     (result)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_proc  = s1_valid_r && (out_free || !has_result);
  assign in_ready = !s1_valid_r || s1_proc;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_proc) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_proc && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode         <= in_mode;
      s1_item_r.run_done     <= in_run_done;
      s1_item_r.start_of_row <= in_start_of_row;
      s1_item_r.skip_length  <= in_skip_length;
      s1_item_r.run_length   <= in_run_length;
      s1_item_r.pixel_code   <= in_pixel_code;
    end
    if (s1_proc && has_result) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_r.pixel_index;
  assign out_colour_word = out_r.colour_word;
  assign out_status      = out_r.status;

endmodule

// File: design/srld_checker.sv
// ----------------------------------------------------------------------------
// srld_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module srld_checker import srld_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_mode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [INDEX_W-1:0]  out_pixel_index,
  input logic [COLOUR_W-1:0] out_colour_word,
  input logic [STATUS_W-1:0] out_status
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index)
      && $stable(out_colour_word) && $stable(out_status))
    else $error("stalled result changed");

  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_WRITTEN) |-> (out_pixel_index == '0)
      && (out_colour_word == '0))
    else $error("dropped or done result carries data");

  a_written_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_WRITTEN) |-> (out_colour_word[31:24] == ALPHA_OPAQUE))
    else $error("written pixel not opaque");

  a_pixel_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_PIXEL) && !out_valid |=> ##1 out_valid)
    else $error("pixel word produced no result");

endmodule

bind sprite_run_length_pixel_decoder srld_checker u_srld_checker (.*);
